// File: rtl/ppba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppba_pkg;

    localparam int DEF_BLOCK_COUNT     = 16;
    localparam int DEF_BLOCK_PAGES     = 16;
    localparam int DEF_RESERVED_BLOCKS = 8;

    localparam int CMD_W  = 3;
    localparam int PAGE_W = 8;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [PAGE_W-1:0] page_t;

    localparam cmd_t CMD_ALLOC_PAGE  = 3'd0;
    localparam cmd_t CMD_ALLOC_BLOCK = 3'd1;
    localparam cmd_t CMD_ALLOC_GIVEN = 3'd2;
    localparam cmd_t CMD_FREE_PAGE   = 3'd3;
    localparam cmd_t CMD_FREE_BLOCK  = 3'd4;

endpackage

`default_nettype wire

// File: rtl/ppba_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ppba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/page_block_bitmap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// request   in         in_valid / in_ready    cmd, page
// result    out        out_valid / out_ready  ok, page_out
//
// One request at a time, taken in the idle cycle. Alloc page and alloc block scan
// the usage memory one block word per cycle, then load the result into the output
// register. Alloc given block, free page and free block split page into block and
// offset by a reciprocal multiply at accept, then make at most one access to the
// memory: a write for free block, a read-modify-write for the other two.
// Reset leaves blocks below RESERVED_BLOCKS in use through per-block valid bits;
// no clearing pass. A result waits in the output register while the next
// request is taken; a full output register holds the block before its load.

module page_block_bitmap_allocator #(
    parameter int BLOCK_COUNT     = ppba_pkg::DEF_BLOCK_COUNT,
    parameter int BLOCK_PAGES     = ppba_pkg::DEF_BLOCK_PAGES,
    parameter int RESERVED_BLOCKS = ppba_pkg::DEF_RESERVED_BLOCKS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ppba_pkg::CMD_W-1:0]   cmd,
    input  wire logic [ppba_pkg::PAGE_W-1:0]  page,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              ok,
    output logic      [ppba_pkg::PAGE_W-1:0]  page_out
);

    localparam int IDX_W  = $clog2(BLOCK_COUNT);
    localparam int OFF_W  = $clog2(BLOCK_PAGES);
    localparam int PAGE_W = ppba_pkg::PAGE_W;

    localparam int RECIP_SH = 16;
    localparam int RECIP_M  = (2**RECIP_SH + BLOCK_PAGES - 1) / BLOCK_PAGES;
    localparam int PROD_W   = PAGE_W + RECIP_SH + 1;

    localparam logic [BLOCK_PAGES-1:0] FULL_WORD = {BLOCK_PAGES{1'b1}};
    localparam logic [BLOCK_PAGES-1:0] ONE_WORD  = BLOCK_PAGES'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_RMW   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    function automatic logic [OFF_W-1:0] low_zero(input logic [BLOCK_PAGES-1:0] w);
        logic [OFF_W-1:0] r;
        r = '0;
        for (int i = BLOCK_PAGES - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = OFF_W'(i);
            end
        end
        return r;
    endfunction

    logic [2:0]            state_reg, state_next;
    ppba_pkg::cmd_t        cmd_reg, cmd_next;
    ppba_pkg::page_t       page_reg, page_next;
    ppba_pkg::page_t       quo_reg, quo_next;
    logic [OFF_W-1:0]      rem_reg, rem_next;
    logic [IDX_W:0]        scan_idx_reg, scan_idx_next;
    ppba_pkg::page_t       issue_base_reg, issue_base_next;
    ppba_pkg::page_t       chk_base_reg, chk_base_next;
    logic                  pend_reg, pend_next;
    logic                  empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]      empty_idx_reg, empty_idx_next;
    ppba_pkg::page_t       empty_base_reg, empty_base_next;
    logic [IDX_W-1:0]      rd_addr_reg;
    logic [BLOCK_COUNT-1:0] vld_reg, vld_next;
    logic                  res_ok_reg, res_ok_next;
    ppba_pkg::page_t       res_page_reg, res_page_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  ok_reg;
    ppba_pkg::page_t       page_out_reg;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [BLOCK_PAGES-1:0] wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [BLOCK_PAGES-1:0] ram_q;
    logic [BLOCK_PAGES-1:0] word_eff;
    logic                   out_load;

    logic [PROD_W-1:0]      div_prod;
    ppba_pkg::page_t        div_quo;
    ppba_pkg::page_t        div_back;
    logic                   blk_ok;
    logic                   w_zero;
    logic                   w_full;
    logic                   w_last;
    logic [IDX_W-1:0]       e_idx;
    ppba_pkg::page_t        e_base;

    ppba_ram #(
        .WIDTH (BLOCK_PAGES),
        .DEPTH (BLOCK_COUNT)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign word_eff = vld_reg[rd_addr_reg] ? ram_q :
                      ((32'(rd_addr_reg) < 32'(RESERVED_BLOCKS)) ? FULL_WORD : '0);

    assign div_prod = PROD_W'(page) * PROD_W'(RECIP_M);
    assign div_quo  = div_prod[RECIP_SH +: PAGE_W];
    assign div_back = page - div_quo * PAGE_W'(BLOCK_PAGES);
    assign blk_ok   = quo_reg < PAGE_W'(BLOCK_COUNT);

    assign w_zero = word_eff == '0;
    assign w_full = word_eff == FULL_WORD;
    assign w_last = rd_addr_reg == IDX_W'(BLOCK_COUNT - 1);
    assign e_idx  = empty_found_reg ? empty_idx_reg : rd_addr_reg;
    assign e_base = empty_found_reg ? empty_base_reg : chk_base_reg;

    assign in_ready  = state_reg == S_IDLE;
    assign out_load  = (state_reg == S_PUSH) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign page_out  = page_out_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        page_next        = page_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        scan_idx_next    = scan_idx_reg;
        issue_base_next  = issue_base_reg;
        chk_base_next    = chk_base_reg;
        pend_next        = 1'b0;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        empty_base_next  = empty_base_reg;
        vld_next         = vld_reg;
        res_ok_next      = res_ok_reg;
        res_page_next    = res_page_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = '0;

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next         = cmd;
                    page_next        = page;
                    quo_next         = div_quo;
                    rem_next         = div_back[OFF_W-1:0];
                    scan_idx_next    = '0;
                    issue_base_next  = '0;
                    empty_found_next = 1'b0;
                    res_ok_next      = 1'b0;
                    res_page_next    = '0;
                    case (cmd)
                        ppba_pkg::CMD_ALLOC_PAGE,
                        ppba_pkg::CMD_ALLOC_BLOCK:
                        begin
                            state_next = S_SCAN;
                        end
                        ppba_pkg::CMD_ALLOC_GIVEN,
                        ppba_pkg::CMD_FREE_PAGE,
                        ppba_pkg::CMD_FREE_BLOCK:
                        begin
                            state_next = S_CHECK;
                        end
                        default:
                        begin
                            state_next = S_PUSH;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                state_next = S_PUSH;
                if (blk_ok)
                begin
                    case (cmd_reg)
                        ppba_pkg::CMD_FREE_BLOCK:
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = quo_reg[IDX_W-1:0];
                            wr_data       = '0;
                            vld_next[wr_addr] = 1'b1;
                            res_ok_next   = 1'b1;
                            res_page_next = page_reg;
                        end
                        ppba_pkg::CMD_FREE_PAGE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = quo_reg[IDX_W-1:0];
                            state_next = S_RMW;
                        end
                        default:
                        begin
                            if (rem_reg == '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = quo_reg[IDX_W-1:0];
                                state_next = S_RMW;
                            end
                        end
                    endcase
                end
            end

            S_RMW:
            begin
                state_next = S_PUSH;
                if (cmd_reg == ppba_pkg::CMD_FREE_PAGE)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = rd_addr_reg;
                    wr_data       = word_eff & ~(ONE_WORD << rem_reg);
                    vld_next[wr_addr] = 1'b1;
                    res_ok_next   = 1'b1;
                    res_page_next = page_reg;
                end
                else if (w_zero)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = rd_addr_reg;
                    wr_data       = FULL_WORD;
                    vld_next[wr_addr] = 1'b1;
                    res_ok_next   = 1'b1;
                    res_page_next = page_reg;
                end
            end

            S_SCAN:
            begin
                if (scan_idx_reg < (IDX_W+1)'(BLOCK_COUNT))
                begin
                    rd_en           = 1'b1;
                    rd_addr         = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next   = scan_idx_reg + 1'b1;
                    issue_base_next = issue_base_reg + PAGE_W'(BLOCK_PAGES);
                    pend_next       = 1'b1;
                end
                chk_base_next = issue_base_reg;
                if (pend_reg)
                begin
                    if (cmd_reg == ppba_pkg::CMD_ALLOC_PAGE)
                    begin
                        if (!w_zero && !w_full)
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = rd_addr_reg;
                            wr_data       = word_eff | (ONE_WORD << low_zero(word_eff));
                            vld_next[wr_addr] = 1'b1;
                            res_ok_next   = 1'b1;
                            res_page_next = chk_base_reg + PAGE_W'(low_zero(word_eff));
                            state_next    = S_PUSH;
                        end
                        else if (w_last)
                        begin
                            if (empty_found_reg || w_zero)
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = e_idx;
                                wr_data       = ONE_WORD;
                                vld_next[wr_addr] = 1'b1;
                                res_ok_next   = 1'b1;
                                res_page_next = e_base;
                            end
                            state_next = S_PUSH;
                        end
                        else if (w_zero && !empty_found_reg)
                        begin
                            empty_found_next = 1'b1;
                            empty_idx_next   = rd_addr_reg;
                            empty_base_next  = chk_base_reg;
                        end
                    end
                    else
                    begin
                        if (w_zero)
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = rd_addr_reg;
                            wr_data       = FULL_WORD;
                            vld_next[wr_addr] = 1'b1;
                            res_ok_next   = 1'b1;
                            res_page_next = chk_base_reg;
                            state_next    = S_PUSH;
                        end
                        else if (w_last)
                        begin
                            state_next = S_PUSH;
                        end
                    end
                end
            end

            S_PUSH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pend_reg        <= 1'b0;
            empty_found_reg <= 1'b0;
            scan_idx_reg    <= '0;
            vld_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_reg        <= pend_next;
            empty_found_reg <= empty_found_next;
            scan_idx_reg    <= scan_idx_next;
            vld_reg         <= vld_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        page_reg       <= page_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        issue_base_reg <= issue_base_next;
        chk_base_reg   <= chk_base_next;
        empty_idx_reg  <= empty_idx_next;
        empty_base_reg <= empty_base_next;
        res_ok_reg     <= res_ok_next;
        res_page_reg   <= res_page_next;
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
        if (out_load)
        begin
            ok_reg       <= res_ok_reg;
            page_out_reg <= res_page_reg;
        end
    end

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_CHECK || state_reg == S_RMW || state_reg == S_SCAN))
        else $error("memory write outside a modify state");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < 32'(BLOCK_COUNT)))
        else $error("memory write beyond the map");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (page_out == '0))
        else $error("refused request with nonzero page");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(scan_idx_reg) <= 32'(BLOCK_COUNT))
        else $error("scan index past the map");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request not started");

endmodule

`default_nettype wire
